@@ src/address_balance_select_defines.svh @@
// ----------------------------------------------------------------------------
// Address balance select assertion macros
// Shared concurrent assertion forms, clocked on clock and quiet during reset.
// ----------------------------------------------------------------------------
`ifndef ADDRESS_BALANCE_SELECT_DEFINES_SVH
`define ADDRESS_BALANCE_SELECT_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define ABS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// A condition that, once seen, must be followed by another in the next cycle.
`define ABS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/abs_pkg.sv @@
// ----------------------------------------------------------------------------
// Address balance select package
// Types, constants and register codes shared by the balance select block.
// ----------------------------------------------------------------------------
package abs_pkg;

   localparam int MAX_ENTRIES   = 16;
   localparam int IDX_W         = $clog2(MAX_ENTRIES);
   localparam int CNT_W         = $clog2(MAX_ENTRIES + 1);
   localparam int QUEUE_DEPTH   = 2;
   localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);
   localparam int CSR_INDEX_W   = 4;
   localparam int CSR_DATA_W    = 8;

   // Balance modes.
   localparam logic [1:0] MODE_RANDOM   = 2'd0;
   localparam logic [1:0] MODE_HASH     = 2'd1;
   localparam logic [1:0] MODE_STATIC   = 2'd2;
   localparam logic [1:0] MODE_SHORTEST = 2'd3;

   // Operations.
   localparam logic OP_SELECT = 1'b0;
   localparam logic OP_WRITE  = 1'b1;

   // Register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_BALANCE_MODE   = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ENTRIES_IN_USE = 4'd1;

   typedef struct packed {
      logic        operation;
      logic [3:0]  entry_index;
      logic        entry_is_active;
      logic [31:0] entry_hash;
      logic [15:0] entry_queue;
      logic [31:0] path_hash;
      logic [31:0] authority_hash;
      logic [15:0] random_value;
   } req_type;

   typedef struct packed {
      logic       found;
      logic [3:0] chosen_index;
   } rsp_type;

   typedef struct packed {
      logic [1:0] balance_mode;
      logic [4:0] entries_in_use;
   } cfg_type;

   // One classified beat as the back end consumes it.
   typedef struct packed {
      logic        is_write;
      logic [3:0]  entry_index;
      logic        entry_is_active;
      logic [31:0] entry_hash;
      logic [15:0] entry_queue;
      logic [32:0] request_key;
      logic [15:0] random_value;
   } cmd_type;

endpackage

@@ src/address_balance_select.sv @@
// ----------------------------------------------------------------------------
// Address balance select
// Chooses one active target from a table of sixteen entries by a set mode.
// ----------------------------------------------------------------------------
// Beats enter through a two-deep command queue, so req_full only rises when
// two beats are waiting behind the table walker. A table write is taken
// in the walker's idle step and gives no result. A select walks the entries
// 0 .. entries_in_use-1 one per cycle, with entries_in_use saturated at
// sixteen: the walker starts it from idle, takes one walk step per entry
// and then loads the result register; with no entries in use it goes
// straight from the start to the result step. The walker's single table
// read port sets this pace. The result register holds one
// finished select while the walker goes on with the next beat, and the
// walker waits in its last step only while that register is still full.
// In hash mode the first active entry with the strictly greatest sum of
// path, name and authority hashes (at full width, no wrap) wins; static mode
// takes the first active entry; shortest-queue mode takes the first active
// entry with the least queue length; random mode takes the k-th active entry
// with k = (active count * random_value) >> 16. Inactive entries never win,
// and found is low with chosen_index zero when none is active. After reset
// all entries are inactive; hashes and queue lengths of an entry mean
// something only after it was written. Configuration registers are written
// through the csr_ port, which is always ready, and should only change while
// no select is in flight.
// ----------------------------------------------------------------------------
module address_balance_select (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_push,
   output logic                               req_full,
   input  abs_pkg::req_type                   req_data,
   output logic                               rsp_empty,
   input  logic                               rsp_pop,
   output abs_pkg::rsp_type                   rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [abs_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [abs_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   abs_pkg::cfg_type cfg_ff, cfg_in;
   abs_pkg::cmd_type front_cmd;
   abs_pkg::cmd_type queue_cmd;
   logic             queue_valid;
   logic             queue_pop;
   logic             rsp_valid;

   // Configuration registers; writes to indexes beyond the list are dropped.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            abs_pkg::CSR_BALANCE_MODE:   cfg_in.balance_mode   = csr_wdata[1:0];
            abs_pkg::CSR_ENTRIES_IN_USE: cfg_in.entries_in_use = csr_wdata[4:0];
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   abs_front u_front (
      .req_data (req_data),
      .cmd      (front_cmd)
   );

   abs_cmd_queue u_cmd_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (req_push),
      .full     (req_full),
      .data_in  (front_cmd),
      .valid    (queue_valid),
      .pop      (queue_pop),
      .data_out (queue_cmd)
   );

   abs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_valid (queue_valid),
      .cmd       (queue_cmd),
      .cmd_pop   (queue_pop),
      .rsp_valid (rsp_valid),
      .rsp       (rsp_data),
      .rsp_pop   (rsp_pop)
   );

   assign rsp_empty = !rsp_valid;

endmodule

@@ src/abs_front.sv @@
// ----------------------------------------------------------------------------
// Address balance select front end
// Classifies an incoming beat and folds the request hashes into one key.
// ----------------------------------------------------------------------------
module abs_front (
   input  abs_pkg::req_type req_data,
   output abs_pkg::cmd_type cmd
);

   always_comb begin
      cmd.is_write        = (req_data.operation == abs_pkg::OP_WRITE);
      cmd.entry_index     = req_data.entry_index;
      cmd.entry_is_active = req_data.entry_is_active;
      cmd.entry_hash      = req_data.entry_hash;
      cmd.entry_queue     = req_data.entry_queue;
      // The path and authority hashes are common to every entry of a walk.
      cmd.request_key     = {1'b0, req_data.path_hash} + {1'b0, req_data.authority_hash};
      cmd.random_value    = req_data.random_value;
   end

endmodule

@@ src/abs_cmd_queue.sv @@
// ----------------------------------------------------------------------------
// Address balance select command queue
// Short ring queue that decouples the front end from the table walker.
// ----------------------------------------------------------------------------
module abs_cmd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  abs_pkg::cmd_type data_in,
   output logic             valid,
   input  logic             pop,
   output abs_pkg::cmd_type data_out
);

   abs_pkg::cmd_type                 slot_ff [abs_pkg::QUEUE_DEPTH];
   logic [abs_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [abs_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [abs_pkg::QCNT_W-1:0]       count_ff, count_in;
   logic                             do_push, do_pop;

   assign full     = (count_ff == abs_pkg::QCNT_W'(abs_pkg::QUEUE_DEPTH));
   assign valid    = (count_ff != '0);
   assign data_out = slot_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == abs_pkg::QPTR_W'(abs_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == abs_pkg::QPTR_W'(abs_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= data_in;
      end
   end

endmodule

@@ src/abs_back.sv @@
// ----------------------------------------------------------------------------
// Address balance select back end
// Holds the target table, walks it one entry per cycle and keeps the result.
// ----------------------------------------------------------------------------
`include "address_balance_select_defines.svh"

module abs_back (
   input  logic             clock,
   input  logic             reset,
   input  abs_pkg::cfg_type cfg,
   input  logic             cmd_valid,
   input  abs_pkg::cmd_type cmd,
   output logic             cmd_pop,
   output logic             rsp_valid,
   output abs_pkg::rsp_type rsp,
   input  logic             rsp_pop
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_WALK   = 2'd1;
   localparam logic [1:0] ST_RESULT = 2'd2;

   localparam int N = abs_pkg::MAX_ENTRIES;
   localparam int IW = abs_pkg::IDX_W;
   localparam int CW = abs_pkg::CNT_W;

   logic [N-1:0]     active_ff, active_in;
   logic [31:0]      hash_mem  [N];
   logic [15:0]      queue_mem [N];
   logic [31:0]      hash_rd_ff;
   logic [15:0]      queue_rd_ff;

   logic [1:0]       state_ff, state_in;
   logic [IW-1:0]    walk_idx_ff, walk_idx_in;
   logic [IW-1:0]    last_idx_ff, last_idx_in;
   logic [32:0]      key_ff, key_in;
   logic [CW-1:0]    k_ff, k_in;
   logic [CW-1:0]    seen_ff, seen_in;
   logic             have_ff, have_in;
   logic [IW-1:0]    best_ff, best_in;
   logic [33:0]      top_ff, top_in;
   logic [15:0]      least_ff, least_in;
   logic             rsp_valid_ff, rsp_valid_in;
   abs_pkg::rsp_type rsp_ff, rsp_in;

   logic [CW-1:0]    examined;
   logic [N-1:0]     in_use_mask;
   logic [CW-1:0]    active_count;
   logic [CW+15:0]   scaled;
   logic             entry_active;
   logic [33:0]      entry_sum;
   logic [15:0]      entry_queue;
   logic             take;
   logic             start;
   logic             do_write;
   logic             rsp_load;

   // Entries taking part in a walk, saturated at the table size.
   assign examined = (32'(cfg.entries_in_use) > N) ? CW'(N) : CW'(cfg.entries_in_use);

   always_comb begin
      for (int i = 0; i < N; i++) begin
         in_use_mask[i] = (i < 32'(examined));
      end
   end

   assign active_count = CW'($countones(active_ff & in_use_mask));
   assign scaled       = (CW + 16)'(active_count) * (CW + 16)'(cmd.random_value);

   assign start    = (state_ff == ST_IDLE) && cmd_valid;
   assign cmd_pop  = start;
   assign do_write = start && cmd.is_write && (32'(cmd.entry_index) < N);
   assign rsp_load = (state_ff == ST_RESULT) && (!rsp_valid_ff || rsp_pop);

   // The table is read one step ahead at the next walk index, so the
   // registered entry always belongs to the current walk index.
   assign entry_active = active_ff[walk_idx_ff];
   assign entry_sum    = {1'b0, key_ff} + {2'b00, hash_rd_ff};
   assign entry_queue  = queue_rd_ff;

   always_comb begin
      case (cfg.balance_mode)
         abs_pkg::MODE_HASH:     take = entry_active && (!have_ff || entry_sum > top_ff);
         abs_pkg::MODE_STATIC:   take = entry_active && !have_ff;
         abs_pkg::MODE_SHORTEST: take = entry_active && (!have_ff || entry_queue < least_ff);
         default:                take = entry_active && (seen_ff == k_ff);
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      walk_idx_in  = walk_idx_ff;
      last_idx_in  = last_idx_ff;
      key_in       = key_ff;
      k_in         = k_ff;
      seen_in      = seen_ff;
      have_in      = have_ff;
      best_in      = best_ff;
      top_in       = top_ff;
      least_in     = least_ff;
      active_in    = active_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;

      if (rsp_valid_ff && rsp_pop) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (do_write) begin
               active_in[IW'(cmd.entry_index)] = cmd.entry_is_active;
            end
            if (start && !cmd.is_write) begin
               walk_idx_in = '0;
               last_idx_in = IW'(examined - 1'b1);
               key_in      = cmd.request_key;
               k_in        = scaled[CW+15:16];
               seen_in     = '0;
               have_in     = 1'b0;
               best_in     = '0;
               state_in    = (examined == '0) ? ST_RESULT : ST_WALK;
            end
         end
         ST_WALK: begin
            if (take) begin
               have_in  = 1'b1;
               best_in  = walk_idx_ff;
               top_in   = entry_sum;
               least_in = entry_queue;
            end
            if (entry_active) begin
               seen_in = seen_ff + 1'b1;
            end
            if (walk_idx_ff == last_idx_ff) begin
               state_in = ST_RESULT;
            end else begin
               walk_idx_in = walk_idx_ff + 1'b1;
            end
         end
         ST_RESULT: begin
            if (rsp_load) begin
               rsp_in.found        = have_ff;
               rsp_in.chosen_index = 4'(best_ff);
               rsp_valid_in        = 1'b1;
               state_in            = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         active_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      walk_idx_ff <= walk_idx_in;
      last_idx_ff <= last_idx_in;
      key_ff      <= key_in;
      k_ff        <= k_in;
      seen_ff     <= seen_in;
      have_ff     <= have_in;
      best_ff     <= best_in;
      top_ff      <= top_in;
      least_ff    <= least_in;
      rsp_ff      <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (do_write) begin
         hash_mem[IW'(cmd.entry_index)]  <= cmd.entry_hash;
         queue_mem[IW'(cmd.entry_index)] <= cmd.entry_queue;
      end
      hash_rd_ff  <= hash_mem[walk_idx_in];
      queue_rd_ff <= queue_mem[walk_idx_in];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   `ABS_ASSERT(a_rsp_from_result, $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_RESULT), "result loaded outside the result state")
   `ABS_ASSERT(a_walk_in_range, (state_ff == ST_WALK) |-> (walk_idx_ff <= last_idx_ff), "walk index ran past the last entry")
   `ABS_ASSERT(a_active_seen_found, ((state_ff == ST_RESULT) && (seen_ff != '0)) |-> have_ff, "active entries seen but no entry chosen")
   `ABS_ASSERT(a_found_is_active, ($rose(rsp_valid_ff) && rsp_ff.found) |-> active_ff[IW'(rsp_ff.chosen_index)], "chosen entry is not active")
   `ABS_ASSERT_NEXT(a_write_single_cycle, (state_ff == ST_IDLE) && cmd_valid && cmd.is_write, state_ff == ST_IDLE, "table write left the idle state")

endmodule

@@ sim/address_balance_select_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Address balance select testbench
// Loads the target table with write beats and checks every select beat
// against a predictor kept in step with the table and the mode registers.
// ----------------------------------------------------------------------------
module address_balance_select_tb;

   localparam int    SETTLE_CYCLES   = 40;       // covers a full walk plus queued writes
   localparam int    RANDOM_PHASES   = 12;
   localparam int    PHASE_BEATS     = 78;
   localparam int    PRESSURE_PHASE  = 9;
   localparam int    PRESSURE_CYCLES = 400;
   localparam longint TIMEOUT_NS     = 64'd10_000_000;

   // -------------------------------------------------------------------------
   // Selection predictor and result scoreboard.
   // It holds its own image of the target table and of both mode registers.
   // Every accepted write beat updates the image; every accepted select beat
   // is resolved against the image at that moment and the predicted choice is
   // queued until the block hands back its result.
   // -------------------------------------------------------------------------
   class balance_scoreboard;
      logic             active    [abs_pkg::MAX_ENTRIES];
      logic [31:0]      name_hash [abs_pkg::MAX_ENTRIES];
      logic [15:0]      queue_len [abs_pkg::MAX_ENTRIES];
      logic [1:0]       mode;
      logic [4:0]       in_use;
      abs_pkg::rsp_type awaited [$];
      int               mismatches;
      int               selects;
      int               writes;
      int               found_count;

      function new();
         for (int i = 0; i < abs_pkg::MAX_ENTRIES; i++) begin
            active[i]    = 1'b0;
            name_hash[i] = '0;
            queue_len[i] = '0;
         end
         mode        = abs_pkg::MODE_RANDOM;
         in_use      = '0;
         mismatches  = 0;
         selects     = 0;
         writes      = 0;
         found_count = 0;
      endfunction

      function void write_register(logic [abs_pkg::CSR_INDEX_W-1:0] idx,
                                   logic [abs_pkg::CSR_DATA_W-1:0] value);
         if (idx == abs_pkg::CSR_BALANCE_MODE)
            mode = value[1:0];
         else if (idx == abs_pkg::CSR_ENTRIES_IN_USE)
            in_use = value[4:0];
      endfunction

      function abs_pkg::rsp_type choose_target(abs_pkg::req_type r);
         int unsigned      span;
         int unsigned      count;
         int unsigned      k;
         int unsigned      seen;
         int unsigned      best;
         logic             have;
         logic             done;
         logic [33:0]      score;
         logic [33:0]      top;
         logic [15:0]      least;
         abs_pkg::rsp_type res;
         span  = (in_use > abs_pkg::MAX_ENTRIES) ? abs_pkg::MAX_ENTRIES : in_use;
         count = 0;
         seen  = 0;
         best  = 0;
         have  = 1'b0;
         done  = 1'b0;
         top   = '0;
         least = '0;
         if (span == 1) begin
            // A single entry in use is taken as it stands, whatever the mode.
            have = active[0];
         end else begin
            case (mode)
               abs_pkg::MODE_HASH: begin
                  for (int unsigned i = 0; i < span; i++) begin
                     if (active[i]) begin
                        score = {2'b00, r.path_hash} + {2'b00, name_hash[i]}
                              + {2'b00, r.authority_hash};
                        if (!have || score > top) begin
                           top  = score;
                           best = i;
                           have = 1'b1;
                        end
                     end
                  end
               end
               abs_pkg::MODE_STATIC: begin
                  for (int unsigned i = 0; i < span; i++) begin
                     if (active[i] && !have) begin
                        best = i;
                        have = 1'b1;
                     end
                  end
               end
               abs_pkg::MODE_SHORTEST: begin
                  for (int unsigned i = 0; i < span; i++) begin
                     if (active[i] && (!have || queue_len[i] < least)) begin
                        least = queue_len[i];
                        best  = i;
                        have  = 1'b1;
                     end
                  end
               end
               default: begin
                  // Random mode: the k-th active entry, k scaled from the
                  // random fraction and always below the active count.
                  for (int unsigned i = 0; i < span; i++)
                     if (active[i])
                        count++;
                  k = (count * r.random_value) >> 16;
                  for (int unsigned i = 0; i < span; i++) begin
                     if (active[i] && !done) begin
                        best = i;
                        have = 1'b1;
                        if (seen == k)
                           done = 1'b1;
                        else
                           seen++;
                     end
                  end
               end
            endcase
         end
         res.found        = have;
         res.chosen_index = have ? 4'(best) : 4'd0;
         return res;
      endfunction

      function void note_request(abs_pkg::req_type r);
         if (r.operation == abs_pkg::OP_WRITE) begin
            active[r.entry_index]    = r.entry_is_active;
            name_hash[r.entry_index] = r.entry_hash;
            queue_len[r.entry_index] = r.entry_queue;
            writes++;
         end else begin
            awaited.push_back(choose_target(r));
            selects++;
         end
      endfunction

      function void check_result(abs_pkg::rsp_type got);
         abs_pkg::rsp_type want;
         if (awaited.size() == 0) begin
            $error("result beat with no select outstanding: found %0d, chosen_index %0d",
                   got.found, got.chosen_index);
            mismatches++;
         end else begin
            want = awaited.pop_front();
            if (got.found !== want.found) begin
               $error("found mismatch: expected %0d, actual %0d", want.found, got.found);
               mismatches++;
            end
            if (got.chosen_index !== want.chosen_index) begin
               $error("chosen_index mismatch: expected %0d, actual %0d",
                      want.chosen_index, got.chosen_index);
               mismatches++;
            end
            if (got.found === 1'b1)
               found_count++;
         end
      endfunction

      function int pending();
         return awaited.size();
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Block under test. Every input starts from a known value.
   // -------------------------------------------------------------------------
   logic                            clock     = 1'b0;
   logic                            reset     = 1'b1;
   logic                            req_push  = 1'b0;
   logic                            req_full;
   abs_pkg::req_type                req_data  = '0;
   logic                            rsp_empty;
   logic                            rsp_pop   = 1'b0;
   abs_pkg::rsp_type                rsp_data;
   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [abs_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [abs_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;

   address_balance_select i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   balance_scoreboard board = new();

   // Idle rates in percent per cycle, changed between stimulus phases.
   int   send_idle_pct = 10;
   int   pop_idle_pct  = 82;
   logic pressure_go   = 1'b0;
   logic hold_pop      = 1'b0;
   int   settings_used = 0;

   initial begin
      forever #10 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // Monitor. Everything is sampled in the active region of the rising edge,
   // so it sees the values that the block itself sees at that edge. Beats
   // are noted in the order register, request, result; a result can never
   // belong to a select accepted at the same edge.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready)
            board.write_register(csr_index, csr_wdata);
         if (req_push && !req_full)
            board.note_request(req_data);
         if (rsp_pop && !rsp_empty)
            board.check_result(rsp_data);
      end
   end

   // Result side: pops at random with the current idle rate, or not at all
   // while a long hold-off is in force.
   always @(posedge clock) begin
      if (reset || hold_pop)
         rsp_pop <= 1'b0;
      else
         rsp_pop <= ($urandom_range(99) >= pop_idle_pct);
   end

   // Long hold-off on the result side. The sender keeps offering beats the
   // whole time, so the command queue and the result register fill and
   // req_full has to hold the input back.
   initial begin
      wait (pressure_go);
      @(posedge clock);
      hold_pop <= 1'b1;
      repeat (PRESSURE_CYCLES) @(posedge clock);
      hold_pop <= 1'b0;
   end

   // Watchdog for a hung handshake.
   initial begin
      #(TIMEOUT_NS);
      $display("tb: failure");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Beat builders. Fields that an operation ignores are filled at random so
   // that every bit of every field is exercised.
   // -------------------------------------------------------------------------
   function automatic abs_pkg::req_type write_item(logic [3:0] idx, logic act,
                                                   logic [31:0] hash,
                                                   logic [15:0] queue);
      abs_pkg::req_type r;
      r.operation       = abs_pkg::OP_WRITE;
      r.entry_index     = idx;
      r.entry_is_active = act;
      r.entry_hash      = hash;
      r.entry_queue     = queue;
      r.path_hash       = $urandom;
      r.authority_hash  = $urandom;
      r.random_value    = 16'($urandom);
      return r;
   endfunction

   function automatic abs_pkg::req_type select_item(logic [31:0] path, logic [31:0] auth,
                                                    logic [15:0] fraction);
      abs_pkg::req_type r;
      r.operation       = abs_pkg::OP_SELECT;
      r.entry_index     = 4'($urandom);
      r.entry_is_active = 1'($urandom);
      r.entry_hash      = $urandom;
      r.entry_queue     = 16'($urandom);
      r.path_hash       = path;
      r.authority_hash  = auth;
      r.random_value    = fraction;
      return r;
   endfunction

   function automatic abs_pkg::req_type random_request();
      logic [31:0] hash;
      logic [15:0] queue;
      logic [31:0] path;
      logic [31:0] auth;
      logic [15:0] fraction;
      // A small pool of shared name hashes and short queue lengths makes
      // ties common, so the first-wins rule gets a real workout.
      hash = $urandom;
      if ($urandom_range(3) == 0)
         hash = 32'hC0DE_0000 | 32'($urandom_range(3));
      else if ($urandom_range(15) == 0)
         hash = '1;
      queue    = ($urandom_range(1) == 0) ? 16'($urandom_range(3)) : 16'($urandom);
      path     = ($urandom_range(15) == 0) ? '1 : $urandom;
      auth     = ($urandom_range(15) == 0) ? '1 : $urandom;
      fraction = 16'($urandom);
      if ($urandom_range(7) == 0)
         fraction = '1;
      else if ($urandom_range(7) == 0)
         fraction = '0;
      if ($urandom_range(99) < 40)
         return write_item(4'($urandom), ($urandom_range(99) < 70), hash, queue);
      return select_item(path, auth, fraction);
   endfunction

   // -------------------------------------------------------------------------
   // Drivers. All inputs change with nonblocking assignments at the rising
   // edge, and each signal gets at most one assignment per edge.
   // -------------------------------------------------------------------------
   task automatic send_request(input abs_pkg::req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_full);
   endtask

   // Waits until every select has been answered, then a little longer for
   // write beats that are still in the queue and give no result.
   task automatic wait_until_idle();
      req_push <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Leaves csr_valid high; configure lowers it once both registers are in.
   task automatic write_register(input logic [abs_pkg::CSR_INDEX_W-1:0] idx,
                                 input logic [abs_pkg::CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic configure(input logic [1:0] mode, input logic [4:0] in_use);
      wait_until_idle();
      write_register(abs_pkg::CSR_BALANCE_MODE, {6'b0, mode});
      write_register(abs_pkg::CSR_ENTRIES_IN_USE, {3'b0, in_use});
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   // -------------------------------------------------------------------------
   // Stimulus.
   // -------------------------------------------------------------------------
   initial begin
      logic [1:0] mode;
      logic [4:0] in_use;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed part. Random mode first: an empty table finds nothing, then
      // the random fraction at its two ends picks the first and the last of
      // three active entries (entry 7 is written inactive and is skipped).
      configure(abs_pkg::MODE_RANDOM, 5'd16);
      send_request(select_item('0, '0, 16'h0000));
      send_request(write_item(4'd0, 1'b1, 32'hFFFF_FFFF, 16'hFFFF));
      send_request(write_item(4'd3, 1'b1, 32'h0000_0000, 16'h0000));
      send_request(write_item(4'd15, 1'b1, 32'hFFFF_FFFF, 16'h0000));
      send_request(write_item(4'd7, 1'b0, 32'h0000_0000, 16'h0000));
      send_request(select_item('0, '0, 16'h0000));
      send_request(select_item('0, '0, 16'hFFFF));

      // Hash election: all-ones hashes carry past 32 bits, and entries 0 and
      // 15 tie at the top so the first one must win.
      configure(abs_pkg::MODE_HASH, 5'd16);
      send_request(select_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0000));
      send_request(select_item(32'h0000_0000, 32'h0000_0000, 16'hFFFF));

      // Static failover: first active entry, then the next one once it drops.
      configure(abs_pkg::MODE_STATIC, 5'd16);
      send_request(select_item('0, '0, 16'h0000));
      send_request(write_item(4'd0, 1'b0, 32'h0000_0000, 16'hFFFF));
      send_request(select_item('0, '0, 16'h0000));

      // Shortest queue: entries 3 and 15 both hold zero, the first wins.
      configure(abs_pkg::MODE_SHORTEST, 5'd16);
      send_request(select_item('0, '0, 16'h0000));

      // One entry in use: only entry 0 counts, active or not.
      configure(abs_pkg::MODE_SHORTEST, 5'd1);
      send_request(select_item('0, '0, 16'h0000));
      send_request(write_item(4'd0, 1'b1, 32'h1234_5678, 16'd5));
      send_request(select_item('0, '0, 16'h0000));

      // No entries in use, then a count beyond the table that saturates.
      configure(abs_pkg::MODE_STATIC, 5'd0);
      send_request(select_item('0, '0, 16'h0000));
      configure(abs_pkg::MODE_HASH, 5'd31);
      send_request(select_item($urandom, $urandom, 16'h0000));

      // Random part. Each phase sets a new mode and entry count; the idle
      // pattern moves from a slow receiver to a slow sender to no idling.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         mode = 2'(p % 4);
         case (p % 6)
            0, 5:    in_use = 5'd16;
            1:       in_use = 5'd1;
            2:       in_use = 5'd0;
            3:       in_use = 5'($urandom_range(16, 2));
            default: in_use = 5'd31;
         endcase
         configure(mode, in_use);
         if (p < 4) begin
            send_idle_pct = 10;
            pop_idle_pct <= 82;
         end else if (p < 8) begin
            send_idle_pct = 82;
            pop_idle_pct <= 10;
         end else begin
            send_idle_pct = 0;
            pop_idle_pct <= 0;
         end
         if (p == PRESSURE_PHASE)
            pressure_go <= 1'b1;
         repeat (PHASE_BEATS) send_request(random_request());
      end

      wait_until_idle();
      $display("Checked %0d selects (%0d found) against %0d table writes,",
               board.selects, board.found_count, board.writes);
      $display("over %0d mode settings with idle, stall and back-pressure phases.",
               settings_used);
      if (board.mismatches == 0 && board.pending() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
